// ===== rtl/ipg_pkg.sv =====
package ipg_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 10;
    localparam int PIX_W      = 16;
    localparam int DIM_W      = 11;
    localparam int TAB_DEPTH  = 256;
    localparam int TAB_AW     = $clog2(TAB_DEPTH);
    localparam int LINE_DEPTH = 3 * MAX_WIDTH;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int C_MIN      = 5;
    localparam int C_MAX      = 250;

    localparam logic MODE_TABLE = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;
    localparam logic KIND_GRAD  = 1'b0;
    localparam logic KIND_DOWN  = 1'b1;
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // One classified item travelling from the front to the back.
    typedef struct packed {
        logic             mode;
        logic [7:0]       tidx;
        logic [PIX_W-1:0] tval;
        logic [PIX_W-1:0] pix;
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
        logic [1:0]       slot;
    } t_item;

endpackage

// ===== rtl/ipg_ram.sv =====
module ipg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ipg_front.sv =====
module ipg_front import ipg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [DIM_W-1:0] i_width,
    input  logic [DIM_W-1:0] i_height,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_mode,
    input  logic [7:0]       i_tidx,
    input  logic [PIX_W-1:0] i_tval,
    input  logic [PIX_W-1:0] i_pix,
    input  logic             i_full,
    output logic             o_push,
    output t_item            o_item
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [1:0]       r_slot, n_slot;
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic [1:0]       slot;
    logic [DIM_W-1:0] y_inc;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        x = ({1'b0, r_col} >= i_width) ? '0 : r_col;
        if ({1'b0, r_row} >= i_height) begin
            y    = '0;
            slot = 2'd0;
        end else begin
            y    = r_row;
            slot = r_slot;
        end
        y_inc  = {1'b0, y} + DIM_W'(1);
        n_col  = x + COL_W'(1);
        n_row  = y;
        n_slot = slot;
        if ({1'b0, x} == i_width - DIM_W'(1)) begin
            n_col = '0;
            if (y_inc >= i_height) begin
                n_row  = '0;
                n_slot = 2'd0;
            end else begin
                n_row  = y_inc[ROW_W-1:0];
                n_slot = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
            end
        end
    end

    always_comb begin
        o_item.mode = i_mode;
        o_item.tidx = i_tidx;
        o_item.tval = i_tval;
        o_item.pix  = i_pix;
        o_item.x    = x;
        o_item.y    = y;
        o_item.slot = slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= 2'd0;
        end else if (o_push && i_mode == MODE_PIXEL) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_slot <= n_slot;
        end
    end

endmodule

// ===== rtl/ipg_fifo.sv =====
module ipg_fifo import ipg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ===== rtl/ipg_back.sv =====
module ipg_back import ipg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [DIM_W-1:0]  i_width,
    input  logic              i_empty,
    input  t_item             i_item,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_kind,
    output logic              o_last,
    output logic [COL_W-1:0]  o_col,
    output logic [ROW_W-1:0]  o_row,
    output logic [PIX_W-1:0]  o_pix,
    output logic [15:0]       o_gx,
    output logic [15:0]       o_gy,
    output logic [39:0]       o_wsq
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_MATH = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    logic [2:0] r_step;
    t_item r_it;
    logic [PIX_W-1:0] r_cen, r_up, r_lf, r_rd_rt, r_t0, r_t1, r_prev, r_first;
    logic [31:0] r_sq;
    logic [32:0] r_s;
    logic [31:0] r_g2;
    logic [48:0] r_pa, r_pb;
    logic [39:0] r_wsq;

    logic [LINE_AW-1:0] line_raddr, line_waddr;
    logic [PIX_W-1:0]   line_rd, tab_rd;
    logic [TAB_AW-1:0]  tab_raddr;
    logic               line_we, tab_we;
    logic [1:0]         s_m1, s_m2;
    logic [DIM_W-1:0]   wm1;
    logic [PIX_W-1:0]   rt;
    logic signed [16:0] dx, dy, gw, hx, hy;
    logic [15:0]        ax, ay, ag;
    logic [16:0]        cen_rnd;
    logic [8:0]         c9;
    logic [TAB_AW-1:0]  c;
    logic [17:0]        dsum;
    logic [49:0]        tot;
    logic               has_g, has_d, out_free, finish;

    function automatic logic [LINE_AW-1:0] line_addr(input logic [1:0] s,
                                                    input logic [COL_W-1:0] col);
        line_addr = LINE_AW'(32'(s) * MAX_WIDTH + 32'(col));
    endfunction

    function automatic logic [15:0] abs17(input logic signed [16:0] v);
        logic signed [16:0] m;
        m = -v;
        abs17 = v[16] ? m[15:0] : v[15:0];
    endfunction

    assign wm1  = i_width - DIM_W'(1);
    assign s_m1 = (r_it.slot == 2'd0) ? 2'd2 : r_it.slot - 2'd1;
    assign s_m2 = (r_it.slot == 2'd0) ? 2'd1 : ((r_it.slot == 2'd1) ? 2'd2 : 2'd0);

    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign line_we    = o_pop && i_item.mode == MODE_PIXEL;
    assign tab_we     = o_pop && i_item.mode == MODE_TABLE;
    assign line_waddr = line_addr(i_item.slot, i_item.x);

    always_comb begin
        case (r_step)
            3'd0:    line_raddr = line_addr(s_m1, r_it.x);
            3'd1:    line_raddr = line_addr(s_m2, r_it.x);
            3'd2:    line_raddr = (r_it.x != '0) ? line_addr(s_m1, r_it.x - COL_W'(1))
                                                 : line_addr(s_m2, wm1[COL_W-1:0]);
            default: line_raddr = line_addr(s_m1, r_it.x + COL_W'(1));
        endcase
    end

    // Response index: rounded intensity clamped into the table's useful span.
    always_comb begin
        cen_rnd = {1'b0, r_cen} + 17'd128;
        c9      = cen_rnd[16:8];
        if (c9 < 9'(C_MIN))      c = TAB_AW'(C_MIN);
        else if (c9 > 9'(C_MAX)) c = TAB_AW'(C_MAX);
        else                     c = c9[TAB_AW-1:0];
        tab_raddr = (r_step == 3'd3) ? c + TAB_AW'(1) : c;
    end

    ipg_ram #(.WIDTH(PIX_W), .DEPTH(LINE_DEPTH)) u_line (
        .i_clk(i_clk), .i_we(line_we), .i_waddr(line_waddr), .i_wdata(i_item.pix),
        .i_raddr(line_raddr), .o_rdata(line_rd)
    );

    ipg_ram #(.WIDTH(PIX_W), .DEPTH(TAB_DEPTH)) u_table (
        .i_clk(i_clk), .i_we(tab_we), .i_waddr(i_item.tidx), .i_wdata(i_item.tval),
        .i_raddr(tab_raddr), .o_rdata(tab_rd)
    );

    always_comb begin
        rt   = ({1'b0, r_it.x} != wm1) ? r_rd_rt : r_first;
        dx   = $signed({1'b0, rt}) - $signed({1'b0, r_lf});
        dy   = $signed({1'b0, r_it.pix}) - $signed({1'b0, r_up});
        gw   = $signed({1'b0, r_t1}) - $signed({1'b0, r_t0});
        ax   = abs17(dx);
        ay   = abs17(dy);
        ag   = abs17(gw);
        hx   = dx >>> 1;
        hy   = dy >>> 1;
        dsum = 18'(r_lf) + 18'(r_cen) + 18'(r_prev) + 18'(r_it.pix) + 18'd2;
        tot  = 50'(r_pa) + 50'(r_pb[48:16]);
        has_g    = r_it.y >= ROW_W'(2);
        has_d    = r_it.x[0] && r_it.y[0];
        out_free = !o_valid || i_ready;
        finish   = (r_state == S_OUT) && out_free &&
                   ((r_step == 3'd1) || !(has_g && has_d));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            o_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free &&
                ((r_step == 3'd0 && has_g) || (r_step == 3'd1) || has_d)) begin
                o_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    if (line_we) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (r_step == 3'd4) begin
                        r_step  <= '0;
                        r_state <= S_MATH;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_MATH: begin
                    if (r_step == 3'd5) begin
                        r_step  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        if (finish) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_step <= 3'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_it <= i_item;
        end
        if (r_state == S_READ) begin
            case (r_step)
                3'd1: r_cen <= line_rd;
                3'd2: r_up  <= line_rd;
                3'd3: begin
                    r_lf <= line_rd;
                    r_t0 <= tab_rd;
                end
                3'd4: begin
                    r_rd_rt <= line_rd;
                    r_t1    <= tab_rd;
                end
                default: ;
            endcase
        end
        if (r_state == S_MATH) begin
            case (r_step)
                3'd0:    r_sq  <= 32'(ax) * 32'(ax);
                3'd1:    r_s   <= 33'(r_sq) + 33'(32'(ay) * 32'(ay));
                3'd2:    r_g2  <= 32'(ag) * 32'(ag);
                3'd3:    r_pa  <= 49'(r_s) * 49'(r_g2[31:16]);
                3'd4:    r_pb  <= 49'(r_s) * 49'(r_g2[15:0]);
                default: r_wsq <= tot[49:10];
            endcase
        end
        if (finish) begin
            r_prev <= r_it.pix;
            if (r_it.x == '0) begin
                r_first <= r_it.pix;
            end
        end
        if (r_state == S_OUT && out_free) begin
            if (r_step == 3'd0 && has_g) begin
                o_kind <= KIND_GRAD;
                o_last <= !has_d;
                o_col  <= r_it.x;
                o_row  <= r_it.y - ROW_W'(1);
                o_pix  <= r_cen;
                o_gx   <= hx[15:0];
                o_gy   <= hy[15:0];
                o_wsq  <= r_wsq;
            end else begin
                o_kind <= KIND_DOWN;
                o_last <= 1'b1;
                o_col  <= r_it.x >> 1;
                o_row  <= r_it.y >> 1;
                o_pix  <= dsum[17:2];
                o_gx   <= '0;
                o_gy   <= '0;
                o_wsq  <= '0;
            end
        end
    end

endmodule

// ===== rtl/image_pyramid_gradient_unit.sv =====
// The back end takes a new item only while idle. A table write does not leave
// the idle state; a pixel holds it through five line-store and table read steps,
// six arithmetic steps and an output load, plus one more output load when it
// yields two results.
// Reset (synchronous, active low) clears the raster position, the queue and
// the sequencer; line store and response table hold no reset value.
module image_pyramid_gradient_unit import ipg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [DIM_W-1:0]  i_cfg_data,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // tdata: table_index[7:0], table_value[23:8], pixel_value[39:24]
    input  logic [39:0]       i_s_tdata,
    // tuser: mode
    input  logic              i_s_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // tdata: col[9:0], row[19:10], pix_out[35:20], grad_x[51:36],
    //        grad_y[67:52], weighted_sq_grad[107:68], zero fill above
    output logic [111:0]      o_m_tdata,
    // tuser: kind
    output logic              o_m_tuser,
    output logic              o_m_tlast
);

    // Level geometry registers and their clamped working values.
    logic [DIM_W-1:0] r_width, r_height;
    logic [DIM_W-1:0] eff_w, eff_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(640);
            r_height <= DIM_W'(480);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_WIDTH) begin
                r_width <= i_cfg_data;
            end else begin
                r_height <= i_cfg_data;
            end
        end
    end

    always_comb begin
        eff_w = r_width;
        if (r_width < DIM_W'(2))         eff_w = DIM_W'(2);
        if (r_width > DIM_W'(MAX_WIDTH)) eff_w = DIM_W'(MAX_WIDTH);
        eff_h = r_height;
        if (r_height < DIM_W'(3))    eff_h = DIM_W'(3);
        if (r_height > DIM_W'(1024)) eff_h = DIM_W'(1024);
    end

    // The front end places each transfer in the raster and queues it; the
    // back end drains the queue at its own pace.
    t_item f_item, q_item;
    logic  f_push, q_full, q_empty, b_pop;

    ipg_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_width(eff_w), .i_height(eff_h),
        .i_valid(i_s_tvalid), .o_ready(o_s_tready),
        .i_mode(i_s_tuser), .i_tidx(i_s_tdata[7:0]),
        .i_tval(i_s_tdata[23:8]), .i_pix(i_s_tdata[39:24]),
        .i_full(q_full), .o_push(f_push), .o_item(f_item)
    );

    ipg_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(f_push), .i_item(f_item), .o_full(q_full),
        .i_pop(b_pop), .o_empty(q_empty), .o_item(q_item)
    );

    logic [COL_W-1:0] o_col;
    logic [ROW_W-1:0] o_row;
    logic [PIX_W-1:0] o_pix;
    logic [15:0]      o_gx, o_gy;
    logic [39:0]      o_wsq;

    ipg_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_width(eff_w),
        .i_empty(q_empty), .i_item(q_item), .o_pop(b_pop),
        .o_valid(o_m_tvalid), .i_ready(i_m_tready),
        .o_kind(o_m_tuser), .o_last(o_m_tlast),
        .o_col(o_col), .o_row(o_row), .o_pix(o_pix),
        .o_gx(o_gx), .o_gy(o_gy), .o_wsq(o_wsq)
    );

    assign o_m_tdata = {4'd0, o_wsq, o_gy, o_gx, o_pix, o_row, o_col};

endmodule

// ===== tb/ipg_checker.sv =====
module ipg_checker import ipg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [DIM_W-1:0]  i_cfg_data,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [39:0]       i_s_tdata,
    input  logic              i_s_tuser,
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [111:0]      i_m_tdata,
    input  logic              i_m_tuser,
    input  logic              i_m_tlast,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic             kind;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] pix;
        logic [15:0]      gx;
        logic [15:0]      gy;
        logic [39:0]      wsq;
        logic             last;
    } t_result;

    t_result          awaited_results[$];
    logic [PIX_W-1:0] rows_held[LINE_DEPTH];
    logic [PIX_W-1:0] slope_table[TAB_DEPTH];
    int unsigned      cur_col, cur_row, cfg_w, cfg_h;

    function automatic int unsigned line_addr(int unsigned r, int unsigned c);
        return (r % 3) * MAX_WIDTH + c;
    endfunction

    // Works out the results of one pixel and advances the raster position.
    task automatic predict_pixel(input logic [PIX_W-1:0] pix);
        int unsigned     w, h, x, y, cen, up, dn, lf, rt, c, sum;
        int              dx, dy, gw;
        longint unsigned sq, g2, a, b, wsq;
        t_result         res;
        t_result         outs[$];
        w = (cfg_w < 2) ? 2 : (cfg_w > MAX_WIDTH ? MAX_WIDTH : cfg_w);
        h = (cfg_h < 3) ? 3 : (cfg_h > 1024 ? 1024 : cfg_h);
        x = (cur_col >= w) ? 0 : cur_col;
        y = (cur_row >= h) ? 0 : cur_row;
        rows_held[line_addr(y, x)] = pix;
        if (y >= 2) begin
            cen = rows_held[line_addr(y - 1, x)];
            up  = rows_held[line_addr(y - 2, x)];
            dn  = rows_held[line_addr(y, x)];
            lf  = (x > 0) ? rows_held[line_addr(y - 1, x - 1)]
                          : rows_held[line_addr(y - 2, w - 1)];
            rt  = (x < w - 1) ? rows_held[line_addr(y - 1, x + 1)]
                              : rows_held[line_addr(y, 0)];
            dx  = int'(rt) - int'(lf);
            dy  = int'(dn) - int'(up);
            sq  = longint'(dx) * dx + longint'(dy) * dy;
            c   = (cen + 128) >> 8;
            if (c < C_MIN) c = C_MIN;
            if (c > C_MAX) c = C_MAX;
            gw  = int'(slope_table[c + 1]) - int'(slope_table[c]);
            g2  = longint'(gw) * gw;
            a   = sq * (g2 >> 16);
            b   = sq * (g2 & 64'hFFFF);
            wsq = (a + (b >> 16)) >> 10;
            if (wsq > 64'hFF_FFFF_FFFF) wsq = 64'hFF_FFFF_FFFF;
            res = '{KIND_GRAD, x[COL_W-1:0], 10'(y - 1), cen[15:0],
                    16'(dx >>> 1), 16'(dy >>> 1), wsq[39:0], 1'b0};
            outs.push_back(res);
        end
        if (x[0] && y[0]) begin
            sum = rows_held[line_addr(y - 1, x - 1)] + rows_held[line_addr(y - 1, x)]
                + rows_held[line_addr(y, x - 1)] + pix;
            res = '{KIND_DOWN, 10'(x >> 1), 10'(y >> 1), 16'((sum + 2) >> 2),
                    16'd0, 16'd0, 40'd0, 1'b0};
            outs.push_back(res);
        end
        if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i]) awaited_results.push_back(outs[i]);
        if (x == w - 1) begin
            x = 0;
            y++;
            if (y >= h) y = 0;
        end else begin
            x++;
        end
        cur_col = x;
        cur_row = y;
    endtask

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            awaited_results.delete();
            cur_col      = 0;
            cur_row      = 0;
            cfg_w        = 640;
            cfg_h        = 480;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WIDTH) cfg_w = i_cfg_data;
                else cfg_h = i_cfg_data;
                cur_col = 0;
                cur_row = 0;
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == MODE_TABLE) slope_table[i_s_tdata[7:0]] = i_s_tdata[23:8];
                else predict_pixel(i_s_tdata[39:24]);
            end
            if (i_m_tvalid && i_m_tready) begin
                got = '{i_m_tuser, i_m_tdata[9:0], i_m_tdata[19:10], i_m_tdata[35:20],
                        i_m_tdata[51:36], i_m_tdata[67:52], i_m_tdata[107:68],
                        i_m_tlast};
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = awaited_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= awaited_results.size();
    end

    initial o_pending = 0;

endmodule

// ===== tb/tb.sv =====
module tb;
    import ipg_pkg::*;

    // Cycles without any transfer on either side before the run is abandoned.
    localparam int STALL_LIMIT = 5000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic             cfg_idx = 1'b0;
    logic [DIM_W-1:0] cfg_data = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [39:0]      s_data = '0;
    logic             s_user = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [111:0]     m_data;
    logic             m_user;
    logic             m_last;
    int               fail_count, pending;
    int               burst_left = 0;
    int               calm_left = 0;
    int               hold_left = 0;
    int               quiet_cycles = 0;
    int               items_sent = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    image_pyramid_gradient_unit u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_s_tvalid(s_valid), .o_s_tready(s_ready), .i_s_tdata(s_data),
        .i_s_tuser(s_user),
        .o_m_tvalid(m_valid), .i_m_tready(m_ready), .o_m_tdata(m_data),
        .o_m_tuser(m_user), .o_m_tlast(m_last)
    );

    ipg_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_s_tvalid(s_valid), .i_s_tready(s_ready), .i_s_tdata(s_data),
        .i_s_tuser(s_user),
        .i_m_tvalid(m_valid), .i_m_tready(m_ready), .i_m_tdata(m_data),
        .i_m_tuser(m_user), .i_m_tlast(m_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // The receiver is mostly ready, stalls for short random spells, and now
    // and then runs a long calm stretch with no stalls at all.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else if (calm_left > 0) begin
            m_ready <= 1'b1;
            calm_left--;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            int r;
            m_ready <= 1'b1;
            r = $urandom_range(0, 15);
            if (r == 0) calm_left = $urandom_range(20, 200);
            else if (r < 5) hold_left = $urandom_range(1, 12);
        end
    end

    // Watchdog: any transfer on either side resets the count.
    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offers one item and returns once it has been taken. The sender works in
    // bursts, dropping valid for a random gap between them.
    task automatic send_item(input logic mode, input logic [7:0] idx,
                             input logic [15:0] val, input logic [15:0] pix);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            repeat (gap) begin
                s_valid <= 1'b0;
                @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid <= 1'b1;
        s_user  <= mode;
        s_data  <= {pix, val, idx};
        do @(posedge clk); while (!s_ready);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_pixel(input logic [15:0] pix);
        send_item(MODE_PIXEL, 8'($urandom), 16'($urandom), pix);
    endtask

    // Registers may only change once every outstanding result has been
    // delivered and the pipeline has drained any trailing table writes.
    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_level(input int w, input int h);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WIDTH;
        cfg_data <= DIM_W'(w);
        @(posedge clk);
        cfg_idx  <= CFG_HEIGHT;
        cfg_data <= DIM_W'(h);
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [15:0] rand_pixel();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // A level of random size, streamed once or twice and sometimes cut short,
    // with an occasional table update mixed into the stream.
    task automatic run_level(input int w, input int h);
        int n;
        set_level(w, h);
        n = w * h * $urandom_range(1, 2);
        if ($urandom_range(0, 3) == 0) n = n - $urandom_range(0, w * h - 1);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0)
                send_item(MODE_TABLE, 8'($urandom), 16'($urandom), 16'($urandom));
            send_pixel(rand_pixel());
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The whole response table is loaded before any gradient can read it,
        // with the lowest and highest values at its two ends.
        for (int i = 0; i < TAB_DEPTH; i++) begin
            send_item(MODE_TABLE, 8'(i),
                      (i == 0) ? 16'h0000 : (i == TAB_DEPTH - 1) ? 16'hFFFF : 16'($urandom),
                      16'($urandom));
        end

        // Directed: a 4x3 level with extreme pixels and intensities either
        // side of the clamp limits, and a table write inside the level.
        set_level(4, 3);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'd1151);
        send_pixel(16'd1152);
        send_pixel(16'd64127);
        send_pixel(16'd64128);
        send_item(MODE_TABLE, 8'd251, 16'hFFFF, 16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        send_pixel(16'h8000);
        send_pixel(16'h7FFF);
        send_pixel(16'h0001);
        send_pixel(16'hFFFE);
        send_item(MODE_TABLE, 8'd5, 16'h0000, 16'hFFFF);

        // The smallest level, and odd sizes leaving a lone column and row.
        set_level(2, 3);
        repeat (12) send_pixel(rand_pixel());
        set_level(5, 7);
        repeat (35) send_pixel(rand_pixel());

        // Sizes below the minimum are raised to the smallest level.
        set_level(0, 1);
        repeat (12) send_pixel(rand_pixel());

        // The tallest level and an oversized width, each streamed only in
        // part so that the run stays short.
        set_level(2, 1024);
        repeat (64) send_pixel(rand_pixel());
        set_level(2047, 3);
        repeat (40) send_pixel(rand_pixel());

        // Random levels until enough items have gone through.
        while (items_sent < 620) run_level($urandom_range(2, 12), $urandom_range(3, 8));

        wait_idle();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== image_pyramid_gradient_unit.f =====
rtl/ipg_pkg.sv
rtl/ipg_ram.sv
rtl/ipg_front.sv
rtl/ipg_fifo.sv
rtl/ipg_back.sv
rtl/image_pyramid_gradient_unit.sv
tb/ipg_checker.sv
tb/tb.sv
